// File: src/dvru_pkg.sv
// shared types and constants of the distance vector route update block
package dvru_pkg;

   localparam int ROUTERS = 8;
   localparam int IDX_W   = 3;
   localparam int CNT_W   = 4;
   localparam int COST_W  = 16;
   localparam int HOP_W   = 4;
   localparam int MISS_W  = 2;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int ENTRIES = ROUTERS * ROUTERS;

   localparam logic [COST_W-1:0] UNREACH    = 16'hFFFF;
   localparam logic [HOP_W-1:0]  NO_HOP     = 4'd8;
   localparam logic [MISS_W-1:0] MISS_LIMIT = 2'd3;
   localparam logic [CNT_W-1:0]  MAX_COUNT  = 4'd8;

   localparam logic [1:0] CSR_SELF  = 2'd0;
   localparam logic [1:0] CSR_MASK  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   typedef enum logic [1:0] {
      ACT_VECTOR = 2'd0,
      ACT_LINK   = 2'd1,
      ACT_MISS   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [COST_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } ram_rd_type;

   typedef struct packed {
      logic [COST_W-1:0] a;
      logic [COST_W-1:0] b;
      logic [COST_W-1:0] lim;
   } alu_req_type;

   typedef struct packed {
      logic [COST_W:0] sum;
      logic            lt;
   } alu_rsp_type;

endpackage

// File: src/dvru_link_ram.sv
// link cost matrix memory, one write and two registered reads per cycle
module dvru_link_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  dvru_pkg::ram_wr_type         wr,
   input  dvru_pkg::ram_rd_type         rd,
   output logic [dvru_pkg::COST_W-1:0]  rd_a_data,
   output logic [dvru_pkg::COST_W-1:0]  rd_b_data
);

   logic [dvru_pkg::COST_W-1:0] mem [dvru_pkg::ENTRIES];
   logic [dvru_pkg::ENTRIES-1:0] valid_ff;
   logic [dvru_pkg::ENTRIES-1:0] valid_in;
   logic [dvru_pkg::COST_W-1:0] rd_a_ff;
   logic [dvru_pkg::COST_W-1:0] rd_b_ff;
   logic                        rd_a_valid_ff;
   logic                        rd_b_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd.addr_a];
      rd_b_ff <= mem[rd.addr_b];
   end

   always_ff @(posedge clock) begin
      rd_a_valid_ff <= valid_ff[rd.addr_a];
      rd_b_valid_ff <= valid_ff[rd.addr_b];
   end

   assign rd_a_data = rd_a_valid_ff ? rd_a_ff : dvru_pkg::UNREACH;
   assign rd_b_data = rd_b_valid_ff ? rd_b_ff : dvru_pkg::UNREACH;

endmodule

// File: src/dvru_alu.sv
// shared 17-bit add and compare unit
module dvru_alu (
   input  dvru_pkg::alu_req_type req,
   output dvru_pkg::alu_rsp_type rsp
);

   always_comb begin
      rsp.sum = {1'b0, req.a} + {1'b0, req.b};
      rsp.lt  = rsp.sum < {1'b0, req.lim};
   end

endmodule

// File: src/distance_vector_route_update_core.sv
// Distance vector route table: each item is a vector entry, a link cost change or a missed
// update. A vector entry without last_entry, an ignored miss and an unknown action are taken
// in the idle state without a recompute. A recompute walks the destinations in order; each
// takes a direct-cost read, a scan over the routers in use through the shared add-compare
// unit fed by the two read ports of the cost matrix, a decision step and a result; if self
// is out of range, the stored route is returned instead. Results wait on rsp_tready. The cost
// matrix reset is done by per-entry valid bits, so the block is ready right after reset.
module distance_vector_route_update_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row_index, col_index, cost
   input  logic [1:0]  req_tuser,   // action
   input  logic        req_tlast,   // last_entry
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // dest_index, route_cost, next_hop_index, changed, link_down
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LINK2  = 6'b000010,
      ST_DEST   = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DECIDE = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   localparam int IW = dvru_pkg::IDX_W;
   localparam int CW = dvru_pkg::COST_W;
   localparam int HW = dvru_pkg::HOP_W;
   localparam int NW = dvru_pkg::CNT_W;
   localparam int MW = dvru_pkg::MISS_W;
   localparam int RN = dvru_pkg::ROUTERS;

   state_type       state_ff, state_in;
   logic [IW-1:0]   self_ff, self_in;
   logic [RN-1:0]   mask_ff, mask_in;
   logic [NW-1:0]   count_ff, count_in;
   logic [CW-1:0]   best_cost_ff [RN];
   logic [CW-1:0]   best_cost_in [RN];
   logic [HW-1:0]   next_hop_ff [RN];
   logic [HW-1:0]   next_hop_in [RN];
   logic [MW-1:0]   miss_ff [RN];
   logic [MW-1:0]   miss_in [RN];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]   d_ff, d_in;
   logic [NW-1:0]   k_ff, k_in;
   logic            down_ff, down_in;
   logic [CW-1:0]   best_ff, best_in;
   logic [HW-1:0]   hop_ff, hop_in;
   logic [CW-1:0]   direct_ff, direct_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [IW-1:0]   rd_k_ff, rd_k_in;
   logic            first_ff, first_in;
   logic [IW-1:0]   link_row_ff, link_row_in;
   logic [CW-1:0]   link_cost_ff, link_cost_in;
   logic [CW-1:0]   out_cost_ff, out_cost_in;
   logic [HW-1:0]   out_hop_ff, out_hop_in;
   logic            out_changed_ff, out_changed_in;
   logic            out_last_ff, out_last_in;

   dvru_pkg::action_type  act;
   dvru_pkg::ram_wr_type  wr;
   dvru_pkg::ram_rd_type  rd;
   dvru_pkg::alu_req_type alu_req;
   dvru_pkg::alu_rsp_type alu_rsp;
   logic [CW-1:0] rd_a_data;
   logic [CW-1:0] rd_b_data;
   logic [IW-1:0] row;
   logic [IW-1:0] col;
   logic [CW-1:0] cost;
   logic [NW-1:0] n;
   logic          self_ok;
   logic          row_ok;
   logic          col_ok;
   logic          issue;
   logic          last_dest;
   logic [HW-1:0] new_hop;

   assign act  = dvru_pkg::action_type'(req_tuser);
   assign row  = req_tdata[2:0];
   assign col  = req_tdata[5:3];
   assign cost = req_tdata[21:6];

   always_comb begin
      if (count_ff == '0) begin
         n = NW'(1);
      end else if (count_ff > dvru_pkg::MAX_COUNT) begin
         n = dvru_pkg::MAX_COUNT;
      end else begin
         n = count_ff;
      end
   end

   assign self_ok   = {1'b0, self_ff} < n;
   assign row_ok    = {1'b0, row} < n;
   assign col_ok    = {1'b0, col} < n;
   assign issue     = k_ff < n;
   assign last_dest = ({1'b0, d_ff} + NW'(1)) == n;
   assign new_hop   = (hop_ff == {1'b0, self_ff}) ? {1'b0, d_ff} : hop_ff;

   dvru_link_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .rd        (rd),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   dvru_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_comb begin
      self_in  = self_ff;
      mask_in  = mask_ff;
      count_in = count_ff;
      if (csr_we) begin
         unique case (csr_addr)
            dvru_pkg::CSR_SELF:  self_in  = csr_wdata[IW-1:0];
            dvru_pkg::CSR_MASK:  mask_in  = csr_wdata[RN-1:0];
            dvru_pkg::CSR_COUNT: count_in = csr_wdata[NW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      best_cost_in   = best_cost_ff;
      next_hop_in    = next_hop_ff;
      miss_in        = miss_ff;
      rsp_valid_in   = rsp_valid_ff;
      d_in           = d_ff;
      k_in           = k_ff;
      down_in        = down_ff;
      best_in        = best_ff;
      hop_in         = hop_ff;
      direct_in      = direct_ff;
      rd_valid_in    = rd_valid_ff;
      rd_k_in        = rd_k_ff;
      first_in       = first_ff;
      link_row_in    = link_row_ff;
      link_cost_in   = link_cost_ff;
      out_cost_in    = out_cost_ff;
      out_hop_in     = out_hop_ff;
      out_changed_in = out_changed_ff;
      out_last_in    = out_last_ff;
      wr             = '0;
      rd             = '0;
      alu_req.a      = rd_a_data;
      alu_req.b      = rd_b_data;
      alu_req.lim    = best_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               d_in    = '0;
               down_in = 1'b0;
               case (act)
                  dvru_pkg::ACT_VECTOR: begin
                     if (row_ok && col_ok) begin
                        wr.en        = 1'b1;
                        wr.addr      = {row, col};
                        wr.data      = cost;
                        miss_in[row] = '0;
                     end
                     if (req_tlast) begin
                        state_in = ST_DEST;
                     end
                  end
                  dvru_pkg::ACT_LINK: begin
                     link_row_in  = row;
                     link_cost_in = cost;
                     if (row_ok && self_ok) begin
                        wr.en    = 1'b1;
                        wr.addr  = {self_ff, row};
                        wr.data  = cost;
                        state_in = ST_LINK2;
                     end else begin
                        state_in = ST_DEST;
                     end
                  end
                  dvru_pkg::ACT_MISS: begin
                     if (row_ok && row != self_ff && mask_ff[row]
                         && miss_ff[row] < dvru_pkg::MISS_LIMIT) begin
                        miss_in[row] = miss_ff[row] + MW'(1);
                        if (miss_ff[row] == dvru_pkg::MISS_LIMIT - MW'(1)) begin
                           if (self_ok) begin
                              wr.en   = 1'b1;
                              wr.addr = {self_ff, row};
                              wr.data = dvru_pkg::UNREACH;
                           end
                           best_cost_in[row] = dvru_pkg::UNREACH;
                           next_hop_in[row]  = dvru_pkg::NO_HOP;
                           down_in           = 1'b1;
                           state_in          = ST_DEST;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LINK2: begin
            wr.en    = 1'b1;
            wr.addr  = {link_row_ff, self_ff};
            wr.data  = link_cost_ff;
            state_in = ST_DEST;
         end
         ST_DEST: begin
            out_last_in = last_dest;
            if (self_ok) begin
               rd.addr_a   = {self_ff, d_ff};
               k_in        = '0;
               best_in     = dvru_pkg::UNREACH;
               hop_in      = dvru_pkg::NO_HOP;
               rd_valid_in = 1'b0;
               first_in    = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               out_cost_in    = best_cost_ff[d_ff];
               out_hop_in     = next_hop_ff[d_ff];
               out_changed_in = 1'b0;
               rsp_valid_in   = 1'b1;
               state_in       = ST_RESP;
            end
         end
         ST_SCAN: begin
            first_in = 1'b0;
            if (first_ff) begin
               direct_in = rd_a_data;
            end
            rd.addr_a   = {self_ff, k_ff[IW-1:0]};
            rd.addr_b   = {k_ff[IW-1:0], d_ff};
            rd_valid_in = issue;
            rd_k_in     = k_ff[IW-1:0];
            if (issue) begin
               k_in = k_ff + NW'(1);
            end else begin
               state_in = ST_DECIDE;
            end
            if (rd_valid_ff && mask_ff[rd_k_ff] && alu_rsp.lt) begin
               best_in = alu_rsp.sum[CW-1:0];
               hop_in  = {1'b0, rd_k_ff};
            end
         end
         ST_DECIDE: begin
            alu_req.a   = best_ff;
            alu_req.b   = '0;
            alu_req.lim = direct_ff;
            if (alu_rsp.lt) begin
               best_cost_in[d_ff] = best_ff;
               next_hop_in[d_ff]  = new_hop;
               out_cost_in        = best_ff;
               out_hop_in         = new_hop;
               out_changed_in     = 1'b1;
            end else begin
               out_cost_in    = best_cost_ff[d_ff];
               out_hop_in     = next_hop_ff[d_ff];
               out_changed_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + IW'(1);
                  state_in = ST_DEST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         self_ff      <= '0;
         mask_ff      <= '0;
         count_ff     <= dvru_pkg::MAX_COUNT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RN; i++) begin
            best_cost_ff[i] <= dvru_pkg::UNREACH;
            next_hop_ff[i]  <= dvru_pkg::NO_HOP;
            miss_ff[i]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         self_ff      <= self_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         best_cost_ff <= best_cost_in;
         next_hop_ff  <= next_hop_in;
         miss_ff      <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff           <= d_in;
      k_ff           <= k_in;
      down_ff        <= down_in;
      best_ff        <= best_in;
      hop_ff         <= hop_in;
      direct_ff      <= direct_in;
      rd_valid_ff    <= rd_valid_in;
      rd_k_ff        <= rd_k_in;
      first_ff       <= first_in;
      link_row_ff    <= link_row_in;
      link_cost_ff   <= link_cost_in;
      out_cost_ff    <= out_cost_in;
      out_hop_ff     <= out_hop_in;
      out_changed_ff <= out_changed_in;
      out_last_ff    <= out_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, down_ff, out_changed_ff, out_hop_ff, out_cost_ff, d_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: src/dvru_checker.sv
// port checker for the distance vector route update core, with its bind
module dvru_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_we,
   input logic [1:0]  csr_addr,
   input logic [7:0]  csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not ready after last result");

   a_hop_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:19] <= 4'd8 && rsp_tdata[31:25] == 7'd0)
      else $error("next hop out of range");

endmodule

bind distance_vector_route_update_core dvru_checker u_dvru_checker (.*);
